// File: hdl/vtn_pkg.sv
package vtn_pkg;

  // Position coordinate range used for saturation
  localparam int COORD_WIDTH = 16;

  // Stages of the root and quotient pipelines
  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 15;

  // Register indexes of the configuration port
  typedef enum logic [2:0] {
    CFG_POS_ROW_X = 3'd0,
    CFG_POS_ROW_Y = 3'd1,
    CFG_POS_ROW_Z = 3'd2,
    CFG_NRM_ROW_X = 3'd3,
    CFG_NRM_ROW_Y = 3'd4,
    CFG_NRM_ROW_Z = 3'd5
  } cfg_idx_t;

  // Identity rows after reset
  localparam logic [63:0] POS_ROW_X_RST = 64'h0000_0000_0000_1000;
  localparam logic [63:0] POS_ROW_Y_RST = 64'h0000_0000_1000_0000;
  localparam logic [63:0] POS_ROW_Z_RST = 64'h0000_1000_0000_0000;
  localparam logic [47:0] NRM_ROW_X_RST = 48'h0000_0000_1000;
  localparam logic [47:0] NRM_ROW_Y_RST = 48'h0000_1000_0000;
  localparam logic [47:0] NRM_ROW_Z_RST = 48'h1000_0000_0000;

  // Sideband that travels with an item once the normal signs are known
  typedef struct packed {
    logic [2:0][15:0] pos;
    logic [2:0]       neg;
    logic             degen;
  } side_t;

endpackage

// File: hdl/vertex_transform_with_normals_core.sv
// Channel   Handshake              Payload
// -------   ---------------------  ----------------------------------------------
// input     start & !busy          in_pos_x/y/z, in_nrm_x/y/z (signed Q4.12)
// result    out_valid (strobe)     out_pos_x/y/z, out_nrm_x/y/z, out_normal_degenerate
// config    cfg_valid & cfg_ready  cfg_index, cfg_data
//
// One vertex enters per cycle; busy stays low. An item passes 56 register stages, the first
// loaded at the edge that takes it: six front stages, 33 square root and 16 quotient
// stages and the output register, which strobes the result.
// Reset clears the valid bits and loads identity matrices into the row registers.
// The result side cannot stall, so the pipeline advances every cycle.
module vertex_transform_with_normals_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] in_pos_x,
  input  logic signed [15:0] in_pos_y,
  input  logic signed [15:0] in_pos_z,
  input  logic signed [15:0] in_nrm_x,
  input  logic signed [15:0] in_nrm_y,
  input  logic signed [15:0] in_nrm_z,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data,
  output logic               out_valid,
  output logic signed [15:0] out_pos_x,
  output logic signed [15:0] out_pos_y,
  output logic signed [15:0] out_pos_z,
  output logic signed [15:0] out_nrm_x,
  output logic signed [15:0] out_nrm_y,
  output logic signed [15:0] out_nrm_z,
  output logic               out_normal_degenerate
);

  localparam int SQ = vtn_pkg::SQRT_STEPS;
  localparam int DV = vtn_pkg::DIV_STEPS;
  localparam logic signed [34:0] SAT_HI =
    35'((64'sd1 <<< (vtn_pkg::COORD_WIDTH - 1)) - 64'sd1);
  localparam logic signed [34:0] SAT_LO = -SAT_HI - 35'sd1;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // Configuration rows
  logic [63:0] pos_row_r [3];
  logic [47:0] nrm_row_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_row_r[0] <= vtn_pkg::POS_ROW_X_RST;
      pos_row_r[1] <= vtn_pkg::POS_ROW_Y_RST;
      pos_row_r[2] <= vtn_pkg::POS_ROW_Z_RST;
      nrm_row_r[0] <= vtn_pkg::NRM_ROW_X_RST;
      nrm_row_r[1] <= vtn_pkg::NRM_ROW_Y_RST;
      nrm_row_r[2] <= vtn_pkg::NRM_ROW_Z_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        vtn_pkg::CFG_POS_ROW_X: pos_row_r[0] <= cfg_data;
        vtn_pkg::CFG_POS_ROW_Y: pos_row_r[1] <= cfg_data;
        vtn_pkg::CFG_POS_ROW_Z: pos_row_r[2] <= cfg_data;
        vtn_pkg::CFG_NRM_ROW_X: nrm_row_r[0] <= cfg_data[47:0];
        vtn_pkg::CFG_NRM_ROW_Y: nrm_row_r[1] <= cfg_data[47:0];
        vtn_pkg::CFG_NRM_ROW_Z: nrm_row_r[2] <= cfg_data[47:0];
        default: ;
      endcase
    end
  end

  logic signed [15:0] pin [3];
  logic signed [15:0] nin [3];
  assign pin[0] = in_pos_x;
  assign pin[1] = in_pos_y;
  assign pin[2] = in_pos_z;
  assign nin[0] = in_nrm_x;
  assign nin[1] = in_nrm_y;
  assign nin[2] = in_nrm_z;

  // Valid bits of the front stages
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic sqv_r [SQ+1];
  logic dvv_r [DV+1];
  logic outv_r;

  // Stage 1: products
  logic signed [31:0] pprod_r [3][3];
  logic signed [15:0] ptrans_r [3];
  logic signed [31:0] nprod_r [3][3];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      ptrans_r[i] <= signed'(pos_row_r[i][63:48]);
      for (int k = 0; k < 3; k++) begin
        pprod_r[i][k] <= signed'(pos_row_r[i][16*k +: 16]) * pin[k];
        nprod_r[i][k] <= signed'(nrm_row_r[i][16*k +: 16]) * nin[k];
      end
    end
  end

  // Stage 2: position round and saturate, normal dot products
  logic signed [34:0] pacc [3];
  logic signed [34:0] pq   [3];
  logic signed [34:0] psat [3];
  logic [15:0]        pos2_r [3];
  logic signed [33:0] nv2_r  [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pacc[i] = 35'(pprod_r[i][0]) + 35'(pprod_r[i][1]) + 35'(pprod_r[i][2])
              + (35'(ptrans_r[i]) <<< 12) + 35'sd2048;
      pq[i]   = pacc[i] >>> 12;
      if (pq[i] < SAT_LO)      psat[i] = SAT_LO;
      else if (pq[i] > SAT_HI) psat[i] = SAT_HI;
      else                     psat[i] = pq[i];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      pos2_r[i] <= psat[i][15:0];
      nv2_r[i]  <= 34'(nprod_r[i][0]) + 34'(nprod_r[i][1]) + 34'(nprod_r[i][2]);
    end
  end

  // Stage 3: magnitudes, signs and the common leading-one word
  logic [33:0] nabs [3];
  logic [31:0] mag3_r [3];
  logic [31:0] orv3_r;
  vtn_pkg::side_t side3_r;
  logic [31:0] orv;

  always_comb begin
    orv = '0;
    for (int i = 0; i < 3; i++) begin
      nabs[i] = nv2_r[i][33] ? 34'(-nv2_r[i]) : 34'(nv2_r[i]);
      orv     = orv | nabs[i][31:0];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      mag3_r[i]       <= nabs[i][31:0];
      side3_r.pos[i]  <= pos2_r[i];
      side3_r.neg[i]  <= nv2_r[i][33];
    end
    orv3_r        <= orv;
    side3_r.degen <= (orv == '0);
  end

  // Stage 4: shift amount that brings the largest magnitude into [2^30, 2^31)
  logic [4:0] lsh;
  logic [31:0] mag4_r [3];
  logic        rsh4_r;
  logic [4:0]  lsh4_r;
  vtn_pkg::side_t side4_r;

  always_comb begin
    lsh = '0;
    for (int b = 0; b <= 30; b++) begin
      if (orv3_r[b]) lsh = 5'(30 - b);
    end
  end

  always_ff @(posedge clk) begin
    mag4_r  <= mag3_r;
    rsh4_r  <= orv3_r[31];
    lsh4_r  <= lsh;
    side4_r <= side3_r;
  end

  // Stage 5: apply the shift
  logic [31:0] shl [3];
  logic [30:0] sm5_r [3];
  vtn_pkg::side_t side5_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      shl[i] = rsh4_r ? (mag4_r[i] >> 1) : (mag4_r[i] << lsh4_r);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) sm5_r[i] <= shl[i][30:0];
    side5_r <= side4_r;
  end

  // Stage 6: squares
  logic [61:0] sq6_r [3];
  logic [30:0] sm6_r [3];
  vtn_pkg::side_t side6_r;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) sq6_r[i] <= sm5_r[i] * sm5_r[i];
    sm6_r   <= sm5_r;
    side6_r <= side5_r;
  end

  // Square root: entry 0 holds the sum of squares, each later entry one root digit
  logic [63:0] sqx_r [SQ+1];
  logic [63:0] sqr_r [SQ+1];
  logic [30:0] sqsm_r [SQ+1][3];
  vtn_pkg::side_t sqside_r [SQ+1];
  logic [63:0] sqx_nxt [SQ];
  logic [63:0] sqr_nxt [SQ];
  logic [63:0] sqtry   [SQ];

  always_comb begin
    for (int k = 0; k < SQ; k++) begin
      sqtry[k] = sqr_r[k] + (64'd1 << (62 - 2 * k));
      if (sqx_r[k] >= sqtry[k]) begin
        sqx_nxt[k] = sqx_r[k] - sqtry[k];
        sqr_nxt[k] = (sqr_r[k] >> 1) + (64'd1 << (62 - 2 * k));
      end else begin
        sqx_nxt[k] = sqx_r[k];
        sqr_nxt[k] = sqr_r[k] >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    sqx_r[0]    <= 64'(sq6_r[0]) + 64'(sq6_r[1]) + 64'(sq6_r[2]);
    sqr_r[0]    <= '0;
    sqsm_r[0]   <= sm6_r;
    sqside_r[0] <= side6_r;
    for (int k = 0; k < SQ; k++) begin
      sqx_r[k+1]    <= sqx_nxt[k];
      sqr_r[k+1]    <= sqr_nxt[k];
      sqsm_r[k+1]   <= sqsm_r[k];
      sqside_r[k+1] <= sqside_r[k];
    end
  end

  // Quotient: one bit per stage, three lanes sharing the divisor 2*len
  logic [31:0] len;
  logic [47:0] rem_r [DV+1][3];
  logic [14:0] quo_r [DV+1][3];
  logic [32:0] dvd_r [DV+1];
  vtn_pkg::side_t dvside_r [DV+1];
  logic [47:0] rem_nxt [DV][3];
  logic [14:0] quo_nxt [DV][3];
  logic [47:0] dsh [DV];

  assign len = sqr_r[SQ][31:0];

  always_comb begin
    for (int j = 0; j < DV; j++) begin
      dsh[j] = 48'(dvd_r[j]) << (DV - 1 - j);
      for (int i = 0; i < 3; i++) begin
        rem_nxt[j][i] = rem_r[j][i];
        quo_nxt[j][i] = quo_r[j][i];
        if (rem_r[j][i] >= dsh[j]) begin
          rem_nxt[j][i]             = rem_r[j][i] - dsh[j];
          quo_nxt[j][i][DV - 1 - j] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      rem_r[0][i] <= (48'(sqsm_r[SQ][i]) << 15) + 48'(len);
      quo_r[0][i] <= '0;
    end
    dvd_r[0]    <= {len, 1'b0};
    dvside_r[0] <= sqside_r[SQ];
    for (int j = 0; j < DV; j++) begin
      rem_r[j+1]    <= rem_nxt[j];
      quo_r[j+1]    <= quo_nxt[j];
      dvd_r[j+1]    <= dvd_r[j];
      dvside_r[j+1] <= dvside_r[j];
    end
  end

  // Output register: apply signs, zero a degenerate normal
  logic [15:0] nrm_nxt [3];
  logic [15:0] opos_r [3];
  logic [15:0] onrm_r [3];
  logic        odeg_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (dvside_r[DV].degen)      nrm_nxt[i] = '0;
      else if (dvside_r[DV].neg[i]) nrm_nxt[i] = 16'(-{1'b0, quo_r[DV][i]});
      else                          nrm_nxt[i] = {1'b0, quo_r[DV][i]};
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      opos_r[i] <= dvside_r[DV].pos[i];
      onrm_r[i] <= nrm_nxt[i];
    end
    odeg_r <= dvside_r[DV].degen;
  end

  // Valid bits advance with their items
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
      v4_r   <= 1'b0;
      v5_r   <= 1'b0;
      v6_r   <= 1'b0;
      for (int k = 0; k <= SQ; k++) sqv_r[k] <= 1'b0;
      for (int j = 0; j <= DV; j++) dvv_r[j] <= 1'b0;
      outv_r <= 1'b0;
    end else begin
      v1_r     <= start & ~busy;
      v2_r     <= v1_r;
      v3_r     <= v2_r;
      v4_r     <= v3_r;
      v5_r     <= v4_r;
      v6_r     <= v5_r;
      sqv_r[0] <= v6_r;
      for (int k = 0; k < SQ; k++) sqv_r[k+1] <= sqv_r[k];
      dvv_r[0] <= sqv_r[SQ];
      for (int j = 0; j < DV; j++) dvv_r[j+1] <= dvv_r[j];
      outv_r   <= dvv_r[DV];
    end
  end

  assign out_valid             = outv_r;
  assign out_pos_x             = signed'(opos_r[0]);
  assign out_pos_y             = signed'(opos_r[1]);
  assign out_pos_z             = signed'(opos_r[2]);
  assign out_nrm_x             = signed'(onrm_r[0]);
  assign out_nrm_y             = signed'(onrm_r[1]);
  assign out_nrm_z             = signed'(onrm_r[2]);
  assign out_normal_degenerate = odeg_r;

endmodule
